/* hdl/rcfu_pkg.sv */
// Package for the RC channel frame unpacker.
// Holds frame constants, the status code and the sequencer state types.
// No dependencies.
`default_nettype none

package rcfu_pkg;

	localparam logic [7:0] SYNC_BYTE     = 8'hC8;
	localparam logic [7:0] LEN_BYTE      = 8'h18;
	localparam logic [7:0] TYPE_BYTE     = 8'h16;
	localparam int         CHAN_BITS     = 11;
	localparam int         CHAN_COUNT    = 16;
	localparam int         PAYLOAD_BYTES = 22;
	localparam int         PAY_BITS      = PAYLOAD_BYTES * 8;
	localparam int         HDR_BYTES     = 3;
	localparam int         FRAME_BYTES   = 26;
	localparam int         COUNT_MAX     = 27;
	localparam int         CNT_W         = 5;
	localparam int         BIT_CNT_W     = $clog2(CHAN_BITS);
	localparam int         IDX_W         = $clog2(CHAN_COUNT);

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SYNC  = 2'd1,
		ST_BAD_LEN   = 2'd2,
		ST_BAD_TYPE  = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_ERR,
		S_SHIFT,
		S_LOAD
	} seq_state_t;

	// frame checker to top level
	typedef struct packed {
		logic    pay_wr;     // byte is a payload byte, shift it in
		logic    done;       // frame end item accepted
		status_t status;     // frame verdict, valid with done
	} chk_out_t;

	// top level to payload shifter
	typedef struct packed {
		logic load_byte;
		logic shift_bit;
	} sd_ctl_t;

endpackage

`default_nettype wire

/* hdl/rcfu_check.sv */
// Frame checker: byte counter and header checks for each frame.
// Depends on rcfu_pkg.
`default_nettype none

module rcfu_check (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              frame_end,
	output rcfu_pkg::chk_out_t     chk
);

	logic [rcfu_pkg::CNT_W-1:0] byte_count_q;
	logic                       sync_good_q;
	logic                       length_byte_good_q;
	logic                       type_good_q;

	logic [rcfu_pkg::CNT_W-1:0] count_nxt;
	logic                       sync_nxt;
	logic                       len_nxt;
	logic                       type_nxt;

	// header checks on the current byte position
	always_comb begin
		sync_nxt  = sync_good_q;
		len_nxt   = length_byte_good_q;
		type_nxt  = type_good_q;
		if (byte_count_q == rcfu_pkg::CNT_W'(0))
			sync_nxt = (rx_byte == rcfu_pkg::SYNC_BYTE);
		if (byte_count_q == rcfu_pkg::CNT_W'(1))
			len_nxt = (rx_byte == rcfu_pkg::LEN_BYTE);
		if (byte_count_q == rcfu_pkg::CNT_W'(2))
			type_nxt = (rx_byte == rcfu_pkg::TYPE_BYTE);
		if (byte_count_q < rcfu_pkg::CNT_W'(rcfu_pkg::COUNT_MAX))
			count_nxt = byte_count_q + rcfu_pkg::CNT_W'(1);
		else
			count_nxt = byte_count_q;
	end

	// verdict in check order: sync, then length, then type
	always_comb begin
		chk.pay_wr = accept
			&& byte_count_q >= rcfu_pkg::CNT_W'(rcfu_pkg::HDR_BYTES)
			&& byte_count_q < rcfu_pkg::CNT_W'(rcfu_pkg::HDR_BYTES
				+ rcfu_pkg::PAYLOAD_BYTES);
		chk.done = accept && frame_end;
		priority if (!sync_nxt) begin
			chk.status = rcfu_pkg::ST_BAD_SYNC;
		end else if (!len_nxt || count_nxt != rcfu_pkg::CNT_W'(rcfu_pkg::FRAME_BYTES)) begin
			chk.status = rcfu_pkg::ST_BAD_LEN;
		end else if (!type_nxt) begin
			chk.status = rcfu_pkg::ST_BAD_TYPE;
		end else begin
			chk.status = rcfu_pkg::ST_OK;
		end
	end

	// counter and flags; frame end clears everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q       <= '0;
			sync_good_q        <= 1'b0;
			length_byte_good_q <= 1'b0;
			type_good_q        <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				byte_count_q       <= '0;
				sync_good_q        <= 1'b0;
				length_byte_good_q <= 1'b0;
				type_good_q        <= 1'b0;
			end else begin
				byte_count_q       <= count_nxt;
				sync_good_q        <= sync_nxt;
				length_byte_good_q <= len_nxt;
				type_good_q        <= type_nxt;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/rcfu_serdes.sv */
// Payload shift register and bit-serial channel unpacker.
// Bytes shift in eight bits at a time; channels shift out one bit a cycle while shift_bit is set.
// Depends on rcfu_pkg.
`default_nettype none

module rcfu_serdes (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rcfu_pkg::sd_ctl_t              ctl,
	input  wire logic [7:0]                     rx_byte,
	output logic                                chan_full,
	output logic [rcfu_pkg::CHAN_BITS-1:0]      chan_value
);

	logic [rcfu_pkg::PAY_BITS-1:0]   pay_q;
	logic [rcfu_pkg::CHAN_BITS-1:0]  chan_q;
	logic [rcfu_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
	logic                            bit_last;

	assign bit_last   = (bit_cnt_q == rcfu_pkg::BIT_CNT_W'(rcfu_pkg::CHAN_BITS - 1));
	assign chan_full  = ctl.shift_bit && bit_last;
	assign chan_value = chan_q;

	// payload line: first byte ends at the bottom, LSB first out
	always_ff @(posedge clk) begin
		if (ctl.load_byte) begin
			pay_q <= {rx_byte, pay_q[rcfu_pkg::PAY_BITS-1:8]};
		end else if (ctl.shift_bit) begin
			pay_q  <= {1'b0, pay_q[rcfu_pkg::PAY_BITS-1:1]};
		end
		if (ctl.shift_bit)
			chan_q <= {pay_q[0], chan_q[rcfu_pkg::CHAN_BITS-1:1]};
	end

	// bit counter within one channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
		end else if (ctl.shift_bit) begin
			if (bit_last)
				bit_cnt_q <= '0;
			else
				bit_cnt_q <= bit_cnt_q + rcfu_pkg::BIT_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

/* hdl/rc_channel_frame_unpacker_unit.sv */
// RC channel frame unpacker, top level: result sequencer and output register.
// Instantiates rcfu_check and rcfu_serdes; depends on rcfu_pkg.
//
// Usage:
//   The rx channel (rx_valid, rx_stall, rx_byte, frame_end) takes one link
//   byte per item; frame_end marks the last byte of a frame. Mid-frame bytes
//   are taken one per cycle with no result.
//   When a frame ends, rx_stall rises while the results go out on the res
//   channel (res_valid, res_stall, status, channel_index, channel_value,
//   last). A bad frame gives one error item, loaded from S_ERR once the
//   output register is free. A good frame gives 16 channel items: each
//   channel's 11 bits are shifted bit-serially out of the payload shift
//   register in S_SHIFT, then the channel is loaded into the output
//   register in S_LOAD once that register is free.
//   A stalled result holds in the output register; the unpacker waits
//   until it is taken. rx_stall drops again once the last item is loaded.
//   Reset (arst_n low) clears the byte counter, checks, sequencer and
//   output valid; the payload register is not cleared.
`default_nettype none

module rc_channel_frame_unpacker_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             rx_valid,
	output logic                                  rx_stall,
	input  wire logic [7:0]                       rx_byte,
	input  wire logic                             frame_end,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output logic [1:0]                            status,
	output logic [rcfu_pkg::IDX_W-1:0]            channel_index,
	output logic [rcfu_pkg::CHAN_BITS-1:0]        channel_value,
	output logic                                  last
);

	rcfu_pkg::seq_state_t              state_q, state_nxt;
	rcfu_pkg::status_t                 stat_q;
	rcfu_pkg::chk_out_t                chk;
	rcfu_pkg::sd_ctl_t                 ctl;
	logic [rcfu_pkg::IDX_W-1:0]        idx_q;
	logic                              accept;
	logic                              out_free;
	logic                              load_err;
	logic                              load_chan;
	logic                              chan_full;
	logic [rcfu_pkg::CHAN_BITS-1:0]    chan_value;
	logic                              idx_last;
	logic                              res_valid_q;

	assign rx_stall  = (state_q != rcfu_pkg::S_IDLE);
	assign accept    = rx_valid && !rx_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign idx_last  = (idx_q == rcfu_pkg::IDX_W'(rcfu_pkg::CHAN_COUNT - 1));
	assign res_valid = res_valid_q;

	rcfu_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.chk       (chk)
	);

	rcfu_serdes u_serdes (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rx_byte    (rx_byte),
		.chan_full  (chan_full),
		.chan_value (chan_value)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rcfu_pkg::S_IDLE;
		else
			state_q <= state_nxt;
	end

	// next state and controls
	always_comb begin
		state_nxt     = state_q;
		ctl.load_byte = chk.pay_wr;
		ctl.shift_bit = 1'b0;
		load_err      = 1'b0;
		load_chan     = 1'b0;
		unique case (state_q)
			rcfu_pkg::S_IDLE: begin
				if (chk.done) begin
					if (chk.status == rcfu_pkg::ST_OK)
						state_nxt = rcfu_pkg::S_SHIFT;
					else
						state_nxt = rcfu_pkg::S_ERR;
				end
			end
			rcfu_pkg::S_ERR: begin
				if (out_free) begin
					load_err  = 1'b1;
					state_nxt = rcfu_pkg::S_IDLE;
				end
			end
			rcfu_pkg::S_SHIFT: begin
				ctl.shift_bit = 1'b1;
				if (chan_full)
					state_nxt = rcfu_pkg::S_LOAD;
			end
			rcfu_pkg::S_LOAD: begin
				if (out_free) begin
					load_chan = 1'b1;
					state_nxt = idx_last ? rcfu_pkg::S_IDLE : rcfu_pkg::S_SHIFT;
				end
			end
			default: state_nxt = rcfu_pkg::S_IDLE;
		endcase
	end

	// frame verdict and channel index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= rcfu_pkg::ST_OK;
			idx_q  <= '0;
		end else begin
			if (chk.done) begin
				stat_q <= chk.status;
				idx_q  <= '0;
			end else if (load_chan) begin
				idx_q  <= idx_q + rcfu_pkg::IDX_W'(1);
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load_err || load_chan)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load_err) begin
			status        <= stat_q;
			channel_index <= '0;
			channel_value <= '0;
			last          <= 1'b1;
		end else if (load_chan) begin
			status        <= rcfu_pkg::ST_OK;
			channel_index <= idx_q;
			channel_value <= chan_value;
			last          <= idx_last;
		end
	end

endmodule

`default_nettype wire
